FILE: sv/ata_prs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO read sequencer package
// Shared types, port addresses and status bits for the sequencer modules.
// ----------------------------------------------------------------------------
package ata_prs_pkg;

  localparam int unsigned WordsPerSectorDef = 256;
  localparam int unsigned MaxSectorsPerCmdDef = 256;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [9:0] PortData = 10'h1F0;
  localparam logic [9:0] PortCount = 10'h1F2;
  localparam logic [9:0] PortLbaLo = 10'h1F3;
  localparam logic [9:0] PortLbaMid = 10'h1F4;
  localparam logic [9:0] PortLbaHi = 10'h1F5;
  localparam logic [9:0] PortDrive = 10'h1F6;
  localparam logic [9:0] PortCmd = 10'h1F7;
  localparam logic [9:0] PortCtrl = 10'h3F6;

  localparam logic [7:0] CmdReadPio = 8'h20;
  localparam logic [7:0] DriveLbaBits = 8'hE0;
  localparam logic [27:0] Lba28Limit = 28'hFFF_FFFF;
  localparam logic [19:0] PollReset = 20'd1000000;
  localparam logic [2:0] PauseReads = 3'd3;

  localparam int unsigned StBsy = 7;
  localparam int unsigned StDf = 5;
  localparam int unsigned StDrq = 3;
  localparam int unsigned StErr = 0;

  localparam logic [0:0] CfgDeviceSectors = 1'b0;
  localparam logic [0:0] CfgPollLimit = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_WORD   = 2'd2,
    OP_FINISH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OUT_OK      = 2'd0,
    OUT_BAD_REQ = 2'd1,
    OUT_DRV_ERR = 2'd2,
    OUT_TIMEOUT = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    ACT_FINISH     = 3'd0,
    ACT_POLL       = 3'd1,
    ACT_PAUSE      = 3'd2,
    ACT_DREAD      = 3'd3,
    ACT_SELECT     = 3'd4,
    ACT_COMMAND    = 3'd5,
    ACT_WORD_DREAD = 3'd6,
    ACT_WORD_PAUSE = 3'd7
  } act_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] lba;
    logic [31:0] count;
    logic [15:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  port;
    logic        wide;
    logic [7:0]  write_data;
    logic [15:0] word_out;
    logic [1:0]  outcome;
    logic        last;
  } out_item_t;

  // Burst of results for one accepted transaction.
  typedef struct packed {
    act_e        act;
    logic [31:0] data;
  } desc_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QueueCntW-1:0] fill;
  } queue_status_t;

endpackage

FILE: sv/ata_prs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO read sequencer front end
// Tracks the command sequence and turns each transaction that its phase accepts into a result burst.
// ----------------------------------------------------------------------------
module ata_prs_front #(
  parameter int unsigned WORDS_PER_SECTOR = ata_prs_pkg::WordsPerSectorDef,
  parameter int unsigned MAX_SECTORS_PER_COMMAND = ata_prs_pkg::MaxSectorsPerCmdDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  ata_prs_pkg::in_item_t item_i,
  input  logic [28:0]           device_sectors_i,
  input  logic [19:0]           poll_limit_i,
  output logic                  push_o,
  output ata_prs_pkg::desc_t    desc_o
);

  localparam int unsigned WIDX = $clog2(WORDS_PER_SECTOR + 1);
  localparam int unsigned CW = $clog2(MAX_SECTORS_PER_COMMAND + 1);

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_NB_PRE    = 7'b0000010,
    PH_SEL_PAUSE = 7'b0000100,
    PH_DRQ       = 7'b0001000,
    PH_DATA      = 7'b0010000,
    PH_SEC_PAUSE = 7'b0100000,
    PH_NB_POST   = 7'b1000000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [27:0]     block_q, block_d;
  logic [28:0]     remain_q, remain_d;
  logic [CW-1:0]   chunk_q, chunk_d;
  logic [WIDX-1:0] widx_q, widx_d;
  logic [19:0]     polls_q, polls_d;
  logic [2:0]      pause_q, pause_d;

  logic [7:0]      st;
  logic [32:0]     span;
  logic            bad;
  logic [WIDX-1:0] widx_inc;
  logic [CW-1:0]   chunk_dec;
  logic [28:0]     remain_dec;
  logic [8:0]      chunk_ext;

  function automatic logic [CW-1:0] chunk_of(input logic [28:0] rem);
    chunk_of = (rem > 29'(MAX_SECTORS_PER_COMMAND)) ? CW'(MAX_SECTORS_PER_COMMAND)
                                                    : rem[CW-1:0];
  endfunction

  assign st = item_i.read_data[7:0];
  assign span = {1'b0, item_i.lba} + {1'b0, item_i.count};
  assign bad = (item_i.count == 32'd0) || (item_i.lba[31:28] != 4'd0) ||
               (span > 33'h1000_0000) || (item_i.lba >= {3'b000, device_sectors_i}) ||
               (span > {4'b0000, device_sectors_i});
  assign widx_inc = widx_q + 1'b1;
  assign chunk_dec = (chunk_q != '0) ? chunk_q - 1'b1 : chunk_q;
  assign remain_dec = (remain_q != '0) ? remain_q - 1'b1 : remain_q;
  assign chunk_ext = 9'(chunk_q);

  always_comb begin
    phase_d = phase_q;
    block_d = block_q;
    remain_d = remain_q;
    chunk_d = chunk_q;
    widx_d = widx_q;
    polls_d = polls_q;
    pause_d = pause_q;
    push_o = 1'b0;
    desc_o.act = ata_prs_pkg::ACT_FINISH;
    desc_o.data = '0;
    if (take_i) begin
      if (!item_i.kind) begin
        if (phase_q == PH_IDLE) begin
          push_o = 1'b1;
          if (bad) begin
            desc_o.data = 32'(ata_prs_pkg::OUT_BAD_REQ);
          end else begin
            block_d = item_i.lba[27:0];
            remain_d = item_i.count[28:0];
            chunk_d = chunk_of(item_i.count[28:0]);
            widx_d = '0;
            polls_d = 20'd1;
            desc_o.act = ata_prs_pkg::ACT_POLL;
            phase_d = PH_NB_PRE;
          end
        end
      end else begin
        unique case (phase_q)
          PH_NB_PRE, PH_DRQ, PH_NB_POST: begin
            push_o = 1'b1;
            if (phase_q == PH_DRQ && (st[ata_prs_pkg::StErr] || st[ata_prs_pkg::StDf])) begin
              desc_o.data = 32'(ata_prs_pkg::OUT_DRV_ERR);
              phase_d = PH_IDLE;
            end else if (!st[ata_prs_pkg::StBsy] &&
                         (phase_q != PH_DRQ || st[ata_prs_pkg::StDrq])) begin
              if (phase_q == PH_NB_PRE) begin
                desc_o.act = ata_prs_pkg::ACT_SELECT;
                desc_o.data = 32'(ata_prs_pkg::DriveLbaBits | {4'h0, block_q[27:24]});
                pause_d = ata_prs_pkg::PauseReads;
                phase_d = PH_SEL_PAUSE;
              end else if (phase_q == PH_DRQ) begin
                desc_o.act = ata_prs_pkg::ACT_DREAD;
                widx_d = '0;
                phase_d = PH_DATA;
              end else if (remain_q == '0) begin
                desc_o.data = 32'(ata_prs_pkg::OUT_OK);
                phase_d = PH_IDLE;
              end else begin
                chunk_d = chunk_of(remain_q);
                polls_d = 20'd1;
                desc_o.act = ata_prs_pkg::ACT_POLL;
                phase_d = PH_NB_PRE;
              end
            end else if (polls_q >= poll_limit_i) begin
              desc_o.data = 32'(ata_prs_pkg::OUT_TIMEOUT);
              phase_d = PH_IDLE;
            end else begin
              desc_o.act = ata_prs_pkg::ACT_POLL;
              polls_d = polls_q + 1'b1;
            end
          end
          PH_SEL_PAUSE, PH_SEC_PAUSE: begin
            push_o = 1'b1;
            if (pause_q != 3'd0) begin
              desc_o.act = ata_prs_pkg::ACT_PAUSE;
              pause_d = pause_q - 1'b1;
            end else if (phase_q == PH_SEL_PAUSE) begin
              desc_o.act = ata_prs_pkg::ACT_COMMAND;
              desc_o.data = {chunk_ext[7:0], block_q[23:0]};
              polls_d = 20'd1;
              phase_d = PH_DRQ;
            end else begin
              chunk_d = chunk_dec;
              remain_d = remain_dec;
              block_d = block_q + 1'b1;
              polls_d = 20'd1;
              desc_o.act = ata_prs_pkg::ACT_POLL;
              phase_d = (chunk_dec != '0) ? PH_DRQ : PH_NB_POST;
            end
          end
          PH_DATA: begin
            push_o = 1'b1;
            desc_o.data = {16'h0000, item_i.read_data};
            if (widx_inc < WIDX'(WORDS_PER_SECTOR)) begin
              desc_o.act = ata_prs_pkg::ACT_WORD_DREAD;
              widx_d = widx_inc;
            end else begin
              desc_o.act = ata_prs_pkg::ACT_WORD_PAUSE;
              widx_d = '0;
              pause_d = ata_prs_pkg::PauseReads;
              phase_d = PH_SEC_PAUSE;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      block_q <= '0;
      remain_q <= '0;
      chunk_q <= '0;
      widx_q <= '0;
      polls_q <= '0;
      pause_q <= '0;
    end else begin
      phase_q <= phase_d;
      block_q <= block_d;
      remain_q <= remain_d;
      chunk_q <= chunk_d;
      widx_q <= widx_d;
      polls_q <= polls_d;
      pause_q <= pause_d;
    end
  end

endmodule

FILE: sv/ata_prs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO read sequencer burst queue
// Small FIFO of result bursts between the front end and the back end.
// ----------------------------------------------------------------------------
module ata_prs_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  ata_prs_pkg::desc_t         desc_i,
  input  logic                       pop_i,
  output ata_prs_pkg::desc_t         head_o,
  output ata_prs_pkg::queue_status_t status_o
);

  ata_prs_pkg::desc_t                   slot_q [ata_prs_pkg::QueueDepth];
  logic [ata_prs_pkg::QueuePtrW-1:0]    wr_q, rd_q;
  logic [ata_prs_pkg::QueueCntW-1:0]    fill_q;

  assign head_o = slot_q[rd_q];
  assign status_o.fill = fill_q;
  assign status_o.empty = (fill_q == '0);
  assign status_o.full = (fill_q == ata_prs_pkg::QueueCntW'(ata_prs_pkg::QueueDepth));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      fill_q <= fill_q + ata_prs_pkg::QueueCntW'(push_i) - ata_prs_pkg::QueueCntW'(pop_i);
    end
  end

endmodule

FILE: sv/ata_prs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO read sequencer back end
// Expands the burst at the queue head into result transactions, one a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module ata_prs_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   avail_i,
  input  ata_prs_pkg::desc_t     head_i,
  input  logic                   out_stall_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  output ata_prs_pkg::out_item_t out_data_o
);

  logic [2:0] idx_q, idx_d;
  logic [2:0] len;
  logic       fire;

  always_comb begin
    out_data_o = '0;
    len = 3'd1;
    unique case (head_i.act)
      ata_prs_pkg::ACT_FINISH: begin
        out_data_o.op = ata_prs_pkg::OP_FINISH;
        out_data_o.outcome = head_i.data[1:0];
      end
      ata_prs_pkg::ACT_POLL: begin
        out_data_o.op = ata_prs_pkg::OP_READ;
        out_data_o.port = ata_prs_pkg::PortCmd;
      end
      ata_prs_pkg::ACT_PAUSE: begin
        out_data_o.op = ata_prs_pkg::OP_READ;
        out_data_o.port = ata_prs_pkg::PortCtrl;
      end
      ata_prs_pkg::ACT_DREAD: begin
        out_data_o.op = ata_prs_pkg::OP_READ;
        out_data_o.port = ata_prs_pkg::PortData;
        out_data_o.wide = 1'b1;
      end
      ata_prs_pkg::ACT_SELECT: begin
        len = 3'd2;
        if (idx_q == 3'd0) begin
          out_data_o.op = ata_prs_pkg::OP_WRITE;
          out_data_o.port = ata_prs_pkg::PortDrive;
          out_data_o.write_data = head_i.data[7:0];
        end else begin
          out_data_o.op = ata_prs_pkg::OP_READ;
          out_data_o.port = ata_prs_pkg::PortCtrl;
        end
      end
      ata_prs_pkg::ACT_COMMAND: begin
        len = 3'd6;
        out_data_o.op = ata_prs_pkg::OP_WRITE;
        case (idx_q)
          3'd0: begin
            out_data_o.port = ata_prs_pkg::PortCount;
            out_data_o.write_data = head_i.data[31:24];
          end
          3'd1: begin
            out_data_o.port = ata_prs_pkg::PortLbaLo;
            out_data_o.write_data = head_i.data[7:0];
          end
          3'd2: begin
            out_data_o.port = ata_prs_pkg::PortLbaMid;
            out_data_o.write_data = head_i.data[15:8];
          end
          3'd3: begin
            out_data_o.port = ata_prs_pkg::PortLbaHi;
            out_data_o.write_data = head_i.data[23:16];
          end
          3'd4: begin
            out_data_o.port = ata_prs_pkg::PortCmd;
            out_data_o.write_data = ata_prs_pkg::CmdReadPio;
          end
          default: begin
            // Status poll that follows the command write.
            out_data_o.op = ata_prs_pkg::OP_READ;
            out_data_o.port = ata_prs_pkg::PortCmd;
          end
        endcase
      end
      ata_prs_pkg::ACT_WORD_DREAD, ata_prs_pkg::ACT_WORD_PAUSE: begin
        len = 3'd2;
        if (idx_q == 3'd0) begin
          out_data_o.op = ata_prs_pkg::OP_WORD;
          out_data_o.word_out = head_i.data[15:0];
        end else if (head_i.act == ata_prs_pkg::ACT_WORD_DREAD) begin
          out_data_o.op = ata_prs_pkg::OP_READ;
          out_data_o.port = ata_prs_pkg::PortData;
          out_data_o.wide = 1'b1;
        end else begin
          out_data_o.op = ata_prs_pkg::OP_READ;
          out_data_o.port = ata_prs_pkg::PortCtrl;
        end
      end
      default: begin
        len = 3'd1;
      end
    endcase
    out_data_o.last = (idx_q == len - 1'b1);
  end

  assign out_valid_o = avail_i;
  assign fire = avail_i && !out_stall_i;
  assign pop_o = fire && out_data_o.last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = out_data_o.last ? 3'd0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

FILE: sv/ata_pio_read_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO LBA28 read sequencer
// Host-side sequencer for PIO reads: checks requests, issues the commands and
// status polls, and delivers sector data words in request order.
// Throughput: one input transaction per cycle while the four-entry burst queue
// has room; the back end sends one result per cycle while the output is not
// stalled. Reset is asynchronous and active low: the sequencer goes idle, the
// queue empties and the registers take reset values.
// ----------------------------------------------------------------------------
module ata_pio_read_sequencer_core #(
  parameter int unsigned WORDS_PER_SECTOR = ata_prs_pkg::WordsPerSectorDef,
  parameter int unsigned MAX_SECTORS_PER_COMMAND = ata_prs_pkg::MaxSectorsPerCmdDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  ata_prs_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ata_prs_pkg::out_item_t out_data_o,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_index_i,
  input  logic [28:0]            cfg_data_i
);

  logic [28:0]                device_sectors_q;
  logic [19:0]                poll_limit_q;
  logic                       take;
  logic                       push;
  logic                       pop;
  ata_prs_pkg::desc_t         desc;
  ata_prs_pkg::desc_t         head;
  ata_prs_pkg::queue_status_t qstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_sectors_q <= '0;
      poll_limit_q <= ata_prs_pkg::PollReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ata_prs_pkg::CfgDeviceSectors: device_sectors_q <= cfg_data_i;
        ata_prs_pkg::CfgPollLimit:     poll_limit_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = qstat.full;
  assign take = in_valid_i && !qstat.full;

  ata_prs_front #(
    .WORDS_PER_SECTOR(WORDS_PER_SECTOR),
    .MAX_SECTORS_PER_COMMAND(MAX_SECTORS_PER_COMMAND)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .item_i          (in_data_i),
    .device_sectors_i(device_sectors_q),
    .poll_limit_i    (poll_limit_q),
    .push_o          (push),
    .desc_o          (desc)
  );

  ata_prs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc),
    .pop_i   (pop),
    .head_o  (head),
    .status_o(qstat)
  );

  ata_prs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (!qstat.empty),
    .head_i     (head),
    .out_stall_i(out_stall_i),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

  // The queue never holds more bursts than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.fill <= ata_prs_pkg::QueueCntW'(ata_prs_pkg::QueueDepth))
    else $error("burst queue overfilled");

  // A burst leaves the queue only on its last result transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (out_valid_o && !out_stall_i && out_data_o.last))
    else $error("burst popped before its last result");

  // A finish result always closes its burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.op == ata_prs_pkg::OP_FINISH) |-> out_data_o.last)
    else $error("finish result not marked last");

  // Fill level follows a push without a pop in the previous cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (qstat.fill == $past(qstat.fill) + 1'b1))
    else $error("queue fill did not track a push");

endmodule
